// ===== design/svmk_pkg.sv =====
// Shared types, constants and the power-of-two table function for the SVM kernel block.
package svmk_pkg;

	// default sizes
	localparam int ELEM_WIDTH_DEF      = 16;
	localparam int ACC_WIDTH_DEF       = 48;
	localparam int EXP_TABLE_DEPTH_DEF = 256;

	// fixed field widths
	localparam int OUT_WIDTH   = 48;
	localparam int GAMMA_WIDTH = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int POW_WIDTH   = 17;   // Q1.16, holds 1.0

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 1'd1;

	localparam logic [GAMMA_WIDTH-1:0] GAMMA_RESET = 24'd65536;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [63:0] LN2_Q30   = 64'd744261118;
	localparam logic [POW_WIDTH-1:0] POW_ONE = 17'd65536;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_R1,
		S_R2,
		S_R3,
		S_R4,
		S_R5,
		S_R6,
		S_PUSH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic mul;
		logic acc;
		logic r1;
		logic r2;
		logic r3;
		logic r4;
		logic r5;
		logic r6;
		logic push;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic radial;
	} status_t;

	// 2^(-z/ln2) in Q1.16, z in Q.30, by a 21-term alternating series
	function automatic logic [POW_WIDTH-1:0] pow2_entry(input logic [63:0] z);
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        r;
		term = 64'd1 << 30;
		sum  = signed'(term);
		term = ((term * z) >> 30) / 64'd1;  sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd2;  sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd3;  sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd4;  sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd5;  sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd6;  sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd7;  sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd8;  sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd9;  sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd10; sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd11; sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd12; sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd13; sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd14; sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd15; sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd16; sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd17; sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd18; sum = sum + signed'(term);
		term = ((term * z) >> 30) / 64'd19; sum = sum - signed'(term);
		term = ((term * z) >> 30) / 64'd20; sum = sum + signed'(term);
		r = unsigned'(sum) + (64'd1 << 13);
		return r[30:14];
	endfunction

endpackage

// ===== design/svmk_ctrl.sv =====
// Sequencer for the SVM kernel block: accept, multiply, accumulate, exp steps, output push.
module svmk_ctrl
	import svmk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = s_tvalid;
				if (s_tvalid)
					state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (!status.last)
					state_d = S_IDLE;
				else if (status.radial)
					state_d = S_R1;
				else
					state_d = S_PUSH;
			end
			S_R1: begin
				cmd.r1  = 1'b1;
				state_d = S_R2;
			end
			S_R2: begin
				cmd.r2  = 1'b1;
				state_d = S_R3;
			end
			S_R3: begin
				cmd.r3  = 1'b1;
				state_d = S_R4;
			end
			S_R4: begin
				cmd.r4  = 1'b1;
				state_d = S_R5;
			end
			S_R5: begin
				cmd.r5  = 1'b1;
				state_d = S_R6;
			end
			S_R6: begin
				cmd.r6  = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				// hold until the output register can take the result
				if (slot_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/svmk_dp.sv =====
// Datapath for the SVM kernel block: registers, multiplier, saturating accumulator, exp unit.
module svmk_dp
	import svmk_pkg::*;
#(
	parameter int ELEM_WIDTH      = ELEM_WIDTH_DEF,
	parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [GAMMA_WIDTH-1:0]       cfg_data,
	input  logic signed [ELEM_WIDTH-1:0] a_elem,
	input  logic signed [ELEM_WIDTH-1:0] b_elem,
	input  logic                         last,
	input  cmd_t                         cmd,
	output status_t                      status,
	output logic signed [OUT_WIDTH-1:0]  kernel_value,
	output logic                         saturated
);

	localparam int EW    = ELEM_WIDTH;
	localparam int PW    = 2 * EW + 2;
	localparam int SW    = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

	localparam logic signed [SW-1:0] ACC_HI =
		{{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

	// constant table of 2^(-k/depth)
	logic [POW_WIDTH-1:0] pow2_tab [EXP_TABLE_DEPTH];
	for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
		localparam logic [63:0] ZK = (64'(k) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
		assign pow2_tab[k] = pow2_entry(ZK);
	end

	// configuration
	logic                   mode_q;
	logic [GAMMA_WIDTH-1:0] gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			gamma_q <= GAMMA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KERNEL_MODE: mode_q  <= cfg_data[0];
				REG_GAMMA:       gamma_q <= cfg_data;
				default:         mode_q  <= mode_q;
			endcase
		end
	end

	// payload registers
	logic signed [EW-1:0]  a_q, b_q;
	logic                  last_q;
	logic signed [PW-1:0]  prod_q;
	logic [43:0]           pl_q, ph_q;
	logic                  one_q, zero_q;
	logic [20:0]           x_q;
	logic [21:0]           y_q;
	logic [POW_WIDTH-1:0]  val_q;
	logic [5:0]            ip_q;
	logic [POW_WIDTH-1:0]  res_q;
	logic signed [OUT_WIDTH-1:0] out_data_q;
	logic                  out_sat_q;

	// accumulator state
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic                        clip_q;

	assign status.last   = last_q;
	assign status.radial = mode_q;
	assign kernel_value  = out_data_q;
	assign saturated     = out_sat_q;

	// multiplier operands: a*b, or |a-b| squared
	logic signed [EW:0]     diff;
	logic [EW:0]            mag;
	logic signed [EW+1:0]   opa, opb;
	logic signed [2*EW+3:0] prod_full;

	always_comb begin
		diff      = {a_q[EW-1], a_q} - {b_q[EW-1], b_q};
		mag       = diff[EW] ? unsigned'(-diff) : unsigned'(diff);
		opa       = mode_q ? signed'({1'b0, mag}) : (EW+2)'(a_q);
		opb       = mode_q ? signed'({1'b0, mag}) : (EW+2)'(b_q);
		prod_full = opa * opb;
	end

	// saturating add
	logic signed [SW-1:0] acc_sum;
	assign acc_sum = SW'(acc_q) + SW'(prod_q);

	// exp chain arithmetic
	logic signed [63:0] acc_ext;
	logic [63:0]        gd_full;
	logic [47:0]        x_round;
	logic [37:0]        y_full;
	logic [31:0]        idx_full;
	logic [IDX_W-1:0]   tab_idx;
	logic [23:0]        rnd, shifted;
	logic [POW_WIDTH-1:0] rad_val;

	always_comb begin
		acc_ext  = 64'(acc_q);
		gd_full  = 64'(pl_q) + (64'(ph_q) << 20);
		x_round  = 48'((gd_full + 64'd32768) >> 16);
		y_full   = 38'(x_q) * 38'(LOG2E_Q16) + 38'd32768;
		idx_full = (32'(y_q[15:0]) * 32'(EXP_TABLE_DEPTH)) >> 16;
		tab_idx  = idx_full[IDX_W-1:0];
		rnd      = 24'd1 << (ip_q - 6'd1);
		shifted  = (24'(val_q) + rnd) >> ip_q;
		if (one_q)
			rad_val = POW_ONE;
		else if (zero_q || ip_q >= 6'd24)
			rad_val = '0;
		else if (ip_q == 6'd0)
			rad_val = val_q;
		else
			rad_val = shifted[POW_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.acc) begin
			if (acc_sum > ACC_HI) begin
				acc_q  <= ACC_HI[ACC_WIDTH-1:0];
				clip_q <= 1'b1;
			end else if (acc_sum < ACC_LO) begin
				acc_q  <= ACC_LO[ACC_WIDTH-1:0];
				clip_q <= 1'b1;
			end else begin
				acc_q  <= acc_sum[ACC_WIDTH-1:0];
			end
		end else if (cmd.push) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q    <= a_elem;
			b_q    <= b_elem;
			last_q <= last;
		end
		if (cmd.mul)
			prod_q <= prod_full[PW-1:0];
		if (cmd.r1) begin
			one_q  <= (acc_ext <= 64'sd0) || (gamma_q == '0);
			zero_q <= |acc_ext[62:40];
			pl_q   <= 44'(gamma_q) * 44'(acc_ext[19:0]);
		end
		if (cmd.r2)
			ph_q <= 44'(gamma_q) * 44'(acc_ext[39:20]);
		if (cmd.r3) begin
			x_q <= x_round[20:0];
			if (|x_round[47:21])
				zero_q <= 1'b1;
		end
		if (cmd.r4)
			y_q <= y_full[37:16];
		if (cmd.r5) begin
			val_q <= pow2_tab[tab_idx];
			ip_q  <= y_q[21:16];
		end
		if (cmd.r6)
			res_q <= rad_val;
		if (cmd.push) begin
			out_data_q <= mode_q ? signed'(OUT_WIDTH'(res_q)) : acc_ext[OUT_WIDTH-1:0];
			out_sat_q  <= clip_q;
		end
	end

endmodule

// ===== design/svm_kernel_eval.sv =====
// Top level of the SVM kernel block: linear or radial kernel over streamed element pairs.
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+---------------------------------------------
//  cfg     | in  | cfg_we             | cfg_index: 0 kernel_mode, 1 gamma; cfg_data
//  s       | in  | s_tvalid/s_tready  | a_elem, b_elem in s_tdata; last in s_tlast
//  m       | out | m_tvalid/m_tready  | kernel_value in m_tdata; saturated in m_tuser
//
//  A pair that is not last passes through accept, multiply and accumulate,
//  all in the single shared multiply and accumulator path. A last pair adds a
//  push step in linear mode; in radial mode six exp steps come first (two gamma*d
//  partial products, round, log2(e) scale, table read, final shift), then push.
//  Reset clears the accumulator, the clip flag and the output valid flag; config
//  returns to linear mode and gamma 1.0. The exp table is constant, no fill.
//  One result is held in the output register; pairs of the next vector are
//  accepted while it waits, and a further last pair holds in push until free.
module svm_kernel_eval
	import svmk_pkg::*;
#(
	parameter int ELEM_WIDTH      = ELEM_WIDTH_DEF,
	parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [GAMMA_WIDTH-1:0]   cfg_data,
	// element pair requests
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// a_elem [ELEM_WIDTH-1:0], b_elem above it, zero padding to bytes
	input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                     s_tlast,
	// result requests
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// kernel_value [47:0]
	output logic [OUT_WIDTH-1:0]     m_tdata,
	// saturated [0]
	output logic                     m_tuser
);

	cmd_t    cmd;
	status_t status;

	logic signed [ELEM_WIDTH-1:0] a_elem, b_elem;
	logic signed [OUT_WIDTH-1:0]  kernel_value;

	// unpack the pair
	assign a_elem  = signed'(s_tdata[ELEM_WIDTH-1:0]);
	assign b_elem  = signed'(s_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]);
	assign m_tdata = unsigned'(kernel_value);

	svmk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	svmk_dp #(
		.ELEM_WIDTH      (ELEM_WIDTH),
		.ACC_WIDTH       (ACC_WIDTH),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.a_elem       (a_elem),
		.b_elem       (b_elem),
		.last         (s_tlast),
		.cmd          (cmd),
		.status       (status),
		.kernel_value (kernel_value),
		.saturated    (m_tuser)
	);

endmodule
